### hdl/qrot_pkg.sv
// Package for the quorum replication operation tracker.
// Holds widths, codes, the slot record type and the state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qrot_pkg;

  localparam int SLOTS        = 16;
  localparam int MAX_REPLICAS = 8;
  localparam int SLOT_W       = $clog2(SLOTS);

  localparam logic [1:0] KIND_FAA   = 2'd0;
  localparam logic [1:0] KIND_CAS   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_STATUS   = 3'd1;
  localparam logic [2:0] ERR_SLOT     = 3'd2;
  localparam logic [2:0] ERR_CAPACITY = 3'd3;
  localparam logic [2:0] ERR_REPLICA  = 3'd4;
  localparam logic [2:0] ERR_QUORUM   = 3'd5;

  localparam logic [2:0] REG_REPLICAS = 3'd0;
  localparam logic [2:0] REG_QUORUM   = 3'd1;
  localparam logic [2:0] REG_CAPACITY = 3'd2;
  localparam logic [2:0] REG_TOTAL    = 3'd3;
  localparam logic [2:0] REG_WINDOW   = 3'd4;
  localparam logic [2:0] REG_CLIENT   = 3'd5;
  localparam logic [2:0] REG_EMPTY    = 3'd6;

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_RESERVE   = 2'd1;
  localparam logic [1:0] PH_REPLICATE = 2'd2;

  // One slot record as kept in the slot memory.
  typedef struct packed {
    logic [31:0] gen;
    logic [1:0]  phase;
    logic [31:0] log_index;
    logic [3:0]  responses;
    logic [3:0]  successes;
  } slot_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_HALT
  } state_t;

endpackage
`default_nettype wire

### hdl/qrot_slot_ram.sv
// Slot record memory of the tracker: one write port, one registered read port.
// Depends on qrot_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrot_slot_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [qrot_pkg::SLOT_W-1:0] waddr,
  input  wire qrot_pkg::slot_rec_t       wdata,
  input  wire logic [qrot_pkg::SLOT_W-1:0] raddr,
  output qrot_pkg::slot_rec_t            rdata
);
  import qrot_pkg::*;

  slot_rec_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/quorum_replication_op_tracker_core.sv
// Top level of the quorum replication operation tracker.
// Depends on qrot_pkg and qrot_slot_ram.
//
// The block tracks up to sixteen replicated-log operations. A start word opens the lowest
// free slot in the window and emits a fetch-add post; a completion word is matched
// against the slot record and may produce compare-swap posts (one per replica), a done
// result with a relaunch post while submissions remain, or an error that halts the block
// for good. Slot records live in a synchronous memory with a registered read port; active
// flags are kept in flip-flops so that a free slot is found at once and reset clears them
// at once. Stale memory contents are harmless: a slot record is only trusted when its
// active flag is set, and the generation of an inactive slot is kept in a separate flop
// bank as generation counts must survive. The memory read is launched at the edge that
// accepts a word, the following cycle decides on the record and writes it back, and then
// the result words are delivered one after another in the emission state. A word that
// yields nothing returns to idle after the decision; a refused start never leaves idle.
// The next word is accepted in the cycle after the last result word of the previous one
// has been taken, so stalls on the output hold off the next word.
`timescale 1ns / 1ps
`default_nettype none
module quorum_replication_op_tracker_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: status_ok[0], gen_tag[32:1], slot_tag[48:33], phase_tag[56:49],
  //        replica_tag[64:57], returned_value[128:65], zero fill to 136 bits
  input  wire logic [135:0] in_tdata,
  // tuser: action
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: work_id[63:0], log_index[95:64], error_code[98:96], all_done[99], zero fill
  output logic [103:0]      out_tdata,
  // tuser: kind
  output logic [1:0]        out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_wdata
);
  import qrot_pkg::*;

  // Configuration registers.
  logic [3:0]  replica_count_r, quorum_r;
  logic [31:0] log_capacity_r, total_ops_r;
  logic [4:0]  window_size_r;
  logic [15:0] client_entry_r;
  logic [63:0] empty_marker_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replica_count_r <= 4'd3;
      quorum_r        <= 4'd2;
      log_capacity_r  <= 32'd65536;
      total_ops_r     <= 32'd1000;
      window_size_r   <= 5'd16;
      client_entry_r  <= '0;
      empty_marker_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPLICAS: replica_count_r <= cfg_wdata[3:0];
        REG_QUORUM:   quorum_r        <= cfg_wdata[3:0];
        REG_CAPACITY: log_capacity_r  <= cfg_wdata[31:0];
        REG_TOTAL:    total_ops_r     <= cfg_wdata[31:0];
        REG_WINDOW:   window_size_r   <= cfg_wdata[4:0];
        REG_CLIENT:   client_entry_r  <= cfg_wdata[15:0];
        REG_EMPTY:    empty_marker_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective window and replica count.
  logic [4:0] win;
  logic [3:0] reps;
  always_comb begin
    win = (window_size_r == 5'd0) ? 5'd1 : window_size_r;
    if (win > 5'(SLOTS)) win = 5'(SLOTS);
    reps = (replica_count_r == 4'd0) ? 4'd1 : replica_count_r;
    if (reps > 4'(MAX_REPLICAS)) reps = 4'(MAX_REPLICAS);
  end

  // Control state.
  state_t      state_r, state_nxt;
  logic [SLOTS-1:0] active_r;
  logic [31:0] gen_r [SLOTS];
  logic [31:0] ops_submitted_r, ops_completed_r;
  logic [4:0]  ops_in_flight_r;

  // Latched item.
  logic        act_r, ok_r;
  logic [31:0] gtag_r;
  logic [15:0] stag_r;
  logic [7:0]  ptag_r, rtag_r;
  logic [63:0] val_r;
  logic [SLOT_W-1:0] slot_r;

  // Emission sequencer.
  logic [1:0]  e_kind_r;
  logic [3:0]  e_cnt_r;
  logic [3:0]  e_total_r;
  logic [63:0] e_id_r;
  logic [31:0] e_idx_r;
  logic [2:0]  e_err_r;
  logic        e_done_r;
  logic        relaunch_r;
  logic [31:0] relaunch_gen_r;

  // Memory.
  logic        ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_raddr;
  slot_rec_t   ram_wdata, ram_rdata;

  qrot_slot_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  wire in_fire  = in_tvalid && in_tready;
  wire out_fire = out_tvalid && out_tready;

  // Free slot search at accept: lowest inactive slot below the window.
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i] && (5'(i) < win)) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  wire [15:0] in_stag = in_tdata[48:33];
  wire start_ok = (ops_in_flight_r < win) && (ops_submitted_r < total_ops_r) && free_found;

  // The record of the incoming word is read at the accepting edge, so that it is
  // ready in the decision cycle.
  assign ram_raddr = (state_r == ST_IDLE) ? (in_tuser ? in_stag[SLOT_W-1:0] : free_slot)
                                          : slot_r;

  // Decision on the read record (state ST_READ).
  logic        d_emit;
  logic [1:0]  d_kind;
  logic [3:0]  d_total;
  logic [63:0] d_id;
  logic [31:0] d_idx;
  logic [2:0]  d_err;
  logic        d_done, d_relaunch, d_we;
  slot_rec_t   d_rec;
  logic [3:0]  resp_n, succ_n, remaining;
  logic [4:0]  succ_rem;
  logic [31:0] comp_n;
  logic        ctr_inc_sub, ctr_done;
  wire  [63:0] tag_id = {gtag_r, stag_r, ptag_r, rtag_r};

  always_comb begin
    d_emit = 1'b0; d_kind = KIND_FAA; d_total = 4'd1; d_id = tag_id; d_idx = '0;
    d_err = ERR_NONE; d_done = 1'b0; d_relaunch = 1'b0; d_we = 1'b0;
    d_rec = ram_rdata; ctr_inc_sub = 1'b0; ctr_done = 1'b0;
    resp_n = ram_rdata.responses + ((ram_rdata.responses != 4'hF) ? 4'd1 : 4'd0);
    succ_n = ram_rdata.successes +
             (((val_r == empty_marker_r) && (ram_rdata.successes != 4'hF)) ? 4'd1 : 4'd0);
    remaining = (resp_n < reps) ? reps - resp_n : 4'd0;
    succ_rem  = {1'b0, succ_n} + {1'b0, remaining};
    comp_n    = ops_completed_r + ((ops_completed_r != 32'hFFFF_FFFF) ? 32'd1 : 32'd0);
    if (!act_r) begin
      // Start: record written fresh.
      d_emit = 1'b1; d_kind = KIND_FAA;
      d_id = {gen_r[slot_r] + 32'd1, 16'(slot_r), 8'(PH_RESERVE), 8'd0};
      d_we = 1'b1; ctr_inc_sub = 1'b1;
      d_rec.gen = gen_r[slot_r] + 32'd1; d_rec.phase = PH_RESERVE;
      d_rec.responses = '0; d_rec.successes = '0;
    end else if (!ok_r) begin
      d_emit = 1'b1; d_kind = KIND_ERROR; d_err = ERR_STATUS;
    end else if ({16'd0, stag_r} >= {27'd0, win}) begin
      d_emit = 1'b1; d_kind = KIND_ERROR; d_err = ERR_SLOT;
    end else if (!active_r[slot_r] || gen_r[slot_r] != gtag_r ||
                 {6'd0, ram_rdata.phase} != ptag_r) begin
      d_emit = 1'b0;
    end else if (ptag_r == 8'(PH_RESERVE)) begin
      d_emit = 1'b1;
      if (val_r >= {32'd0, log_capacity_r}) begin
        d_kind = KIND_ERROR; d_err = ERR_CAPACITY;
      end else begin
        d_kind = KIND_CAS; d_total = reps;
        d_id = {gtag_r, stag_r, 8'(PH_REPLICATE), 8'd0}; d_idx = val_r[31:0];
        d_we = 1'b1; d_rec.log_index = val_r[31:0]; d_rec.phase = PH_REPLICATE;
        d_rec.responses = '0; d_rec.successes = '0;
      end
    end else if (ptag_r == 8'(PH_REPLICATE)) begin
      if ({4'd0, rtag_r} >= {8'd0, reps}) begin
        d_emit = 1'b1; d_kind = KIND_ERROR; d_err = ERR_REPLICA;
      end else if (succ_n >= quorum_r) begin
        d_emit = 1'b1; d_kind = KIND_DONE; d_idx = ram_rdata.log_index;
        d_done = comp_n >= total_ops_r; ctr_done = 1'b1;
        d_relaunch = ops_submitted_r < total_ops_r;
        d_total = d_relaunch ? 4'd2 : 4'd1;
        d_we = 1'b1; d_rec.phase = PH_IDLE;
        d_rec.responses = resp_n; d_rec.successes = succ_n;
        if (d_relaunch) begin
          d_rec.gen = gen_r[slot_r] + 32'd1; d_rec.phase = PH_RESERVE;
          d_rec.responses = '0; d_rec.successes = '0;
        end
      end else begin
        d_we = 1'b1; d_rec.responses = resp_n; d_rec.successes = succ_n;
        if (succ_rem < {1'b0, quorum_r}) begin
          d_emit = 1'b1; d_kind = KIND_ERROR; d_err = ERR_QUORUM;
        end
      end
    end
    if (d_kind == KIND_ERROR && d_emit) begin
      d_we = 1'b0; d_total = 4'd1; d_id = tag_id; d_idx = '0; ctr_done = 1'b0;
      d_relaunch = 1'b0; ctr_inc_sub = 1'b0;
    end
  end

  assign ram_we    = (state_r == ST_READ) && d_we;
  assign ram_waddr = slot_r;
  assign ram_wdata = d_rec;

  // Next state.
  wire last_beat = (e_cnt_r + 4'd1 == e_total_r);
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) begin
        state_nxt = (!in_tuser && !start_ok) ? ST_IDLE : ST_READ;
      end
      ST_READ: state_nxt = d_emit ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (out_fire && last_beat) begin
        state_nxt = (e_kind_r == KIND_ERROR) ? ST_HALT : ST_IDLE;
      end
      ST_HALT: state_nxt = ST_HALT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready  = (state_r == ST_IDLE) || (state_r == ST_HALT);
    out_tvalid = (state_r == ST_EMIT);
    out_tlast  = last_beat;
    out_tuser  = e_kind_r;
    out_tdata  = {4'd0, e_done_r, e_err_r, e_idx_r, e_id_r};
    if (e_kind_r == KIND_CAS) begin
      out_tdata[7:0] = 8'(e_cnt_r);
    end else if (e_kind_r == KIND_DONE && e_cnt_r == 4'd1) begin
      out_tuser = KIND_FAA;
      out_tdata = {40'd0, relaunch_gen_r, 16'(slot_r), 8'(PH_RESERVE), 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      active_r <= '0;
      ops_submitted_r <= '0;
      ops_completed_r <= '0;
      ops_in_flight_r <= '0;
      e_cnt_r <= '0;
      for (int i = 0; i < SLOTS; i++) gen_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_fire) begin
        act_r <= in_tuser; ok_r <= in_tdata[0]; gtag_r <= in_tdata[32:1];
        stag_r <= in_stag; ptag_r <= in_tdata[56:49]; rtag_r <= in_tdata[64:57];
        val_r <= in_tdata[128:65];
        slot_r <= in_tuser ? in_stag[SLOT_W-1:0] : free_slot;
      end
      if (state_r == ST_READ) begin
        e_kind_r <= d_kind; e_total_r <= d_total; e_id_r <= d_id; e_idx_r <= d_idx;
        e_err_r <= d_err; e_done_r <= d_done; relaunch_r <= d_relaunch;
        relaunch_gen_r <= gen_r[slot_r] + 32'd1; e_cnt_r <= '0;
        if (ctr_inc_sub) begin
          active_r[slot_r] <= 1'b1; gen_r[slot_r] <= gen_r[slot_r] + 32'd1;
          ops_submitted_r <= ops_submitted_r + 32'd1;
          ops_in_flight_r <= ops_in_flight_r + 5'd1;
        end
        if (ctr_done) begin
          ops_completed_r <= comp_n;
          if (d_relaunch) begin
            gen_r[slot_r] <= gen_r[slot_r] + 32'd1;
            ops_submitted_r <= ops_submitted_r + 32'd1;
          end else begin
            active_r[slot_r] <= 1'b0;
            if (ops_in_flight_r != 5'd0) ops_in_flight_r <= ops_in_flight_r - 5'd1;
          end
        end
      end
      if (state_r == ST_EMIT && out_fire) begin
        e_cnt_r <= e_cnt_r + 4'd1;
      end
    end
  end

  // The memory is only written while a read-decided word is in progress.
  a_we_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_READ) else $error("slot write outside decision cycle");
  // Once halted the block never emits again.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HALT |=> state_r == ST_HALT && !out_tvalid) else $error("halt left");
  // In-flight count never exceeds the slot count.
  a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    ops_in_flight_r <= 5'(SLOTS)) else $error("in-flight overflow");
  // A relaunch word only follows a done word.
  a_relaunch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && e_cnt_r == 4'd1 && e_kind_r == KIND_DONE) |-> relaunch_r)
    else $error("relaunch without cause");

endmodule
`default_nettype wire
